// ----- rtl/sktbl_pkg.sv -----
`default_nettype none
package sktbl_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int KEY_BYTES_DEF = 8;

  localparam int KEY_W     = 64;
  localparam int TAG_W     = 8;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 6;
  localparam int MCOUNT_W  = 7;
  localparam int LISTED_W  = 6;
  localparam int ENTRY_W   = KEY_W + TAG_W;

  localparam logic [LISTED_W-1:0] MAX_LISTED = 6'd63;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_MATCH  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ACK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    entry_key;
    logic [TAG_W-1:0]    entry_tag;
    logic [MCOUNT_W-1:0] match_count;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIMPLE,
    S_SORT_START,
    S_SORT_LDI,
    S_SORT_CMP,
    S_SORT_PUT,
    S_LIST_RD,
    S_LIST_EMIT,
    S_SRCH_START,
    S_SRCH_CMP,
    S_MC_START,
    S_MC_CMP
  } state_t;

  // Keeps the first nbytes bytes and clears every byte after the first zero byte.
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k,
                                                     input logic [3:0] nbytes);
    logic [KEY_W-1:0] r;
    logic             ended;
    r = k;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (ended || (4'(b) >= nbytes)) begin
        r[KEY_W-1-8*b -: 8] = 8'd0;
      end
      if (r[KEY_W-1-8*b -: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic out_item_t make_result(input logic [STATUS_W-1:0] status,
                                            input logic [POS_W-1:0] position,
                                            input logic [KEY_W-1:0] entry_key,
                                            input logic [TAG_W-1:0] entry_tag,
                                            input logic [MCOUNT_W-1:0] match_count,
                                            input logic last);
    out_item_t r;
    r.status      = status;
    r.position    = position;
    r.entry_key   = entry_key;
    r.entry_tag   = entry_tag;
    r.match_count = match_count;
    r.last        = last;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sktbl_ram.sv -----
`default_nettype none
module sktbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_key_table_search_unit.sv -----
// Clear, append and unknown operations give one result beat; search makes one probe per
// halving of the range (at most log2(DEPTH)+1 probes); match-count compares every table
// entry; sort of n entries runs an insertion sort by compare-move steps (at most n(n-1)/2),
// then lists each entry in order. The next operation can be accepted in the cycle after
// the final beat is loaded, so no operation is taken while the last one is still running.
// Reset (synchronous, rst_n low) empties the table and selects ascending order.
`default_nettype none
module sorted_key_table_search_unit
  import sktbl_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [IW-1:0]       mid_r, mid_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [LISTED_W-1:0] n_r, n_nxt;
  logic [MCOUNT_W-1:0] mcount_r, mcount_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                desc_r;

  logic                accept, can_emit, out_load;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key, in_key;
  logic [TAG_W-1:0]    rd_tag;
  logic                cmp_lt, cmp_eq, cmp_gt, out_of_order;
  logic [CW:0]         mid_sum;
  logic [IW-1:0]       mid_c;
  logic                list_last, mc_hit, mc_list;

  sktbl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key = ram_rdata[TAG_W +: KEY_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];
  assign in_key = normalize_key(in_data.key, 4'(KEY_BYTES));

  // Shared comparator: table word against the held key.
  assign cmp_lt       = rd_key < key_r;
  assign cmp_eq       = rd_key == key_r;
  assign cmp_gt       = !cmp_lt && !cmp_eq;
  assign out_of_order = desc_r ? cmp_lt : cmp_gt;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_emit  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_c     = mid_sum[IW:1];
  assign list_last = (idx_r + CW'(1)) == cnt_r;
  assign mc_hit    = cmp_eq;
  assign mc_list   = mc_hit && (n_r < MAX_LISTED);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.operation)
            OP_SORT:   state_nxt = S_SORT_START;
            OP_SEARCH: state_nxt = S_SRCH_START;
            OP_MATCH:  state_nxt = S_MC_START;
            default:   state_nxt = S_SIMPLE;
          endcase
        end
      end
      S_SIMPLE: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_SORT_START: begin
        if (idx_r >= cnt_r) begin
          state_nxt = (cnt_r == '0) ? S_SIMPLE : S_LIST_RD;
        end else begin
          state_nxt = S_SORT_LDI;
        end
      end
      S_SORT_LDI: state_nxt = S_SORT_CMP;
      S_SORT_CMP: begin
        if (out_of_order) begin
          state_nxt = (j_r == IW'(1)) ? S_SORT_PUT : S_SORT_CMP;
        end else begin
          state_nxt = S_SORT_START;
        end
      end
      S_SORT_PUT: state_nxt = S_SORT_START;
      S_LIST_RD:  state_nxt = S_LIST_EMIT;
      S_LIST_EMIT: begin
        if (can_emit) begin
          state_nxt = list_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_SRCH_START: state_nxt = (lo_r >= hi_r) ? S_SIMPLE : S_SRCH_CMP;
      S_SRCH_CMP:   state_nxt = cmp_eq ? S_SIMPLE : S_SRCH_START;
      S_MC_START:   state_nxt = (idx_r >= cnt_r) ? S_SIMPLE : S_MC_CMP;
      S_MC_CMP: begin
        if (!(mc_list && !can_emit)) begin
          state_nxt = S_MC_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    n_nxt         = n_r;
    mcount_nxt    = mcount_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = j_r;
    ram_wdata     = {key_r, tag_r};
    ram_raddr     = idx_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        key_nxt = in_key;
        tag_nxt = in_data.tag;
        res_nxt = make_result(ST_ACK, '0, '0, '0, '0, 1'b1);
        if (accept) begin
          unique case (in_data.operation)
            OP_CLEAR: cnt_nxt = '0;
            OP_APPEND: begin
              if (cnt_r >= CW'(DEPTH)) begin
                res_nxt = make_result(ST_FULL, '0, '0, '0, '0, 1'b1);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[IW-1:0];
                ram_wdata = {in_key, in_data.tag};
                res_nxt   = make_result(ST_ACK, POS_W'(cnt_r[IW-1:0]), in_key,
                                        in_data.tag, '0, 1'b1);
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_SORT: idx_nxt = CW'(1);
            OP_SEARCH: begin
              lo_nxt = '0;
              hi_nxt = cnt_r;
            end
            OP_MATCH: begin
              idx_nxt    = '0;
              n_nxt      = '0;
              mcount_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SIMPLE: begin
        if (can_emit) begin
          out_load = 1'b1;
          out_nxt  = res_r;
        end
      end
      S_SORT_START: begin
        if (idx_r >= cnt_r) begin
          idx_nxt = '0;
        end
      end
      S_SORT_LDI: begin
        key_nxt   = rd_key;
        tag_nxt   = rd_tag;
        j_nxt     = idx_r[IW-1:0];
        ram_raddr = idx_r[IW-1:0] - IW'(1);
      end
      S_SORT_CMP: begin
        ram_we = 1'b1;
        if (out_of_order) begin
          ram_wdata = ram_rdata;
          j_nxt     = j_r - IW'(1);
          ram_raddr = j_r - IW'(2);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SORT_PUT: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + CW'(1);
      end
      S_LIST_RD: ;
      S_LIST_EMIT: begin
        if (can_emit) begin
          out_load = 1'b1;
          out_nxt  = make_result(ST_LISTED, POS_W'(idx_r[IW-1:0]), rd_key, rd_tag,
                                 '0, list_last);
          idx_nxt  = idx_r + CW'(1);
        end
      end
      S_SRCH_START: begin
        mid_nxt   = mid_c;
        ram_raddr = mid_c;
        res_nxt   = make_result(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
      end
      S_SRCH_CMP: begin
        ram_raddr = mid_r;
        if (cmp_eq) begin
          res_nxt = make_result(ST_FOUND, POS_W'(mid_r), rd_key, rd_tag, '0, 1'b1);
        end else if (cmp_gt) begin
          hi_nxt = CW'(mid_r);
        end else begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end
      end
      S_MC_START: begin
        res_nxt = make_result(ST_COUNT, '0, '0, '0, mcount_r, 1'b1);
      end
      S_MC_CMP: begin
        if (mc_list) begin
          if (can_emit) begin
            out_load   = 1'b1;
            out_nxt    = make_result(ST_LISTED, POS_W'(idx_r[IW-1:0]), rd_key, rd_tag,
                                     '0, 1'b0);
            n_nxt      = n_r + LISTED_W'(1);
            mcount_nxt = mcount_r + MCOUNT_W'(1);
            idx_nxt    = idx_r + CW'(1);
          end
        end else begin
          if (mc_hit) begin
            mcount_nxt = mcount_r + MCOUNT_W'(1);
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      desc_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    j_r      <= j_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    n_r      <= n_nxt;
    mcount_r <= mcount_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted operation did not start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && !out_ready))
    else $error("result register overwritten while stalled");

  a_sort_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_CMP) |-> ((j_r != '0) && (CW'(j_r) <= idx_r)))
    else $error("insertion index out of range");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_sorted_key_table_search_unit.sv -----
`timescale 1ns / 100ps
module tb_sorted_key_table_search_unit;
  import sktbl_pkg::*;

  localparam int DEPTH            = DEPTH_DEF;
  localparam int KEY_BYTES        = KEY_BYTES_DEF;
  localparam int RANDOM_ITEMS     = 80;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 64;
  localparam int POOL_SIZE        = 32;

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  logic [KEY_W-1:0] model_keys [DEPTH];
  logic [TAG_W-1:0] model_tags [DEPTH];
  int               model_count = 0;
  logic             model_desc  = 1'b0;

  out_item_t        op_results[$];
  out_item_t        expected_beats[$];
  directed_row_t    directed_rows[$];
  logic [KEY_W-1:0] key_pool[$];

  int   cycle_count    = 0;
  int   mismatches     = 0;
  int   beat_index     = 0;
  int   burst_left     = 0;
  int   random_sent    = 0;
  int   rx_mode        = 0;
  int   rx_mode_left   = 0;
  int   hold_left      = 0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  always #5 clk = ~clk;

  sorted_key_table_search_unit #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // A key is a C string of at most KEY_BYTES bytes, so everything after the first zero byte is dropped.
  function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    bit               ended;
    k = raw;
    ended = 1'b0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (ended || b >= KEY_BYTES) begin
        k[KEY_W-1-8*b -: 8] = 8'd0;
      end else if (k[KEY_W-1-8*b -: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic void sort_entries();
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    int               j;
    for (int i = 1; i < model_count; i++) begin
      k = model_keys[i];
      t = model_tags[i];
      j = i;
      while (j > 0 && (model_desc ? (model_keys[j-1] < k) : (model_keys[j-1] > k))) begin
        model_keys[j] = model_keys[j-1];
        model_tags[j] = model_tags[j-1];
        j--;
      end
      model_keys[j] = k;
      model_tags[j] = t;
    end
  endfunction

  function automatic void predict_beats(input in_item_t it);
    logic [KEY_W-1:0] k;
    int               lo;
    int               hi;
    int               mid;
    int               hits;
    bit               hit;
    k = clean_key(it.key);
    op_results.delete();
    case (it.operation)
      OP_CLEAR: begin
        model_count = 0;
        op_results.push_back(make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
      end
      OP_APPEND: begin
        if (model_count >= DEPTH) begin
          op_results.push_back(make_result(ST_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          model_keys[model_count] = k;
          model_tags[model_count] = it.tag;
          op_results.push_back(make_result(ST_ACK, POS_W'(model_count), k, it.tag, '0, 1'b1));
          model_count++;
        end
      end
      OP_SORT: begin
        sort_entries();
        if (model_count == 0) begin
          op_results.push_back(make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
        end
        for (int i = 0; i < model_count; i++) begin
          op_results.push_back(make_result(ST_LISTED, POS_W'(i), model_keys[i], model_tags[i],
                                           '0, i == model_count - 1));
        end
      end
      OP_SEARCH: begin
        lo = 0;
        hi = model_count - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (k == model_keys[mid]) begin
            op_results.push_back(make_result(ST_FOUND, POS_W'(mid), model_keys[mid],
                                             model_tags[mid], '0, 1'b1));
            hit = 1'b1;
          end else if (k < model_keys[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
        if (!hit) begin
          op_results.push_back(make_result(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1));
        end
      end
      OP_MATCH: begin
        hits = 0;
        for (int i = 0; i < model_count; i++) begin
          if (model_keys[i] == k) begin
            if (hits < int'(MAX_LISTED)) begin
              op_results.push_back(make_result(ST_LISTED, POS_W'(i), model_keys[i],
                                               model_tags[i], '0, 1'b0));
            end
            hits++;
          end
        end
        op_results.push_back(make_result(ST_COUNT, '0, '0, '0, MCOUNT_W'(hits), 1'b1));
      end
      default: begin
        op_results.push_back(make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    $display("MISMATCH at beat %0d, %s: got %h, want %h", beat_index, what, got, want);
    mismatches++;
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("unexpected beat, status", KEY_W'(got.status), '0);
    end else begin
      want = expected_beats.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
      if (got.position !== want.position)
        report_mismatch("position", KEY_W'(got.position), KEY_W'(want.position));
      if (got.entry_key !== want.entry_key)
        report_mismatch("entry_key", got.entry_key, want.entry_key);
      if (got.entry_tag !== want.entry_tag)
        report_mismatch("entry_tag", KEY_W'(got.entry_tag), KEY_W'(want.entry_tag));
      if (got.match_count !== want.match_count)
        report_mismatch("match_count", KEY_W'(got.match_count), KEY_W'(want.match_count));
      if (got.last !== want.last)
        report_mismatch("last", KEY_W'(got.last), KEY_W'(want.last));
    end
    beat_index++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver changes its mood now and then, and holds off once for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode_left <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic send_op(input in_item_t it, input bit typed, input out_item_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_beats(it);
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      foreach (op_results[i]) expected_beats.push_back(op_results[i]);
    end
  endtask

  task automatic drain_and_set_order(input bit do_write, input logic desc);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (8) @(posedge clk);
    if (do_write) begin
      cfg_we <= 1'b1;
      cfg_wdata <= desc;
      @(posedge clk);
      cfg_we <= 1'b0;
      model_desc = desc;
    end
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [TAG_W-1:0] tag, input bit typed,
                         input out_item_t want);
    directed_row_t row;
    row.stim.operation = op;
    row.stim.key = key;
    row.stim.tag = tag;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Random, reused or all-0/1 keys; short tiny-alphabet strings give duplicates and shared prefixes.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = {$urandom, $urandom};
      4, 5, 6: begin
        if (key_pool.size() > 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else k = {$urandom, $urandom};
      end
      7, 8: begin
        k = '0;
        n = $urandom_range(1, KEY_BYTES);
        for (int b = 0; b < n; b++) k[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h41, 8'h44));
      end
      default: k = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return k;
  endfunction

  task automatic send_random(input logic [OP_W-1:0] op);
    in_item_t it;
    it.operation = op;
    it.key = pick_key();
    it.tag = 8'($urandom_range(0, 255));
    if (op == OP_APPEND) begin
      key_pool.push_back(it.key);
      if (key_pool.size() > POOL_SIZE) void'(key_pool.pop_front());
    end
    send_op(it, 1'b0, '0);
    random_sent++;
  endtask

  initial begin
    int n_app;
    int seq;
    add_row(OP_SORT,   '0, '0, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
    add_row(OP_SEARCH, '0, '0, 1'b1, make_result(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1));
    add_row(OP_MATCH,  '0, '0, 1'b1, make_result(ST_COUNT, '0, '0, '0, '0, 1'b1));
    add_row(OP_APPEND, '0, 8'h00, 1'b1, make_result(ST_ACK, 6'd0, '0, 8'h00, '0, 1'b1));
    add_row(OP_APPEND, '1, 8'hFF, 1'b1, make_result(ST_ACK, 6'd1, '1, 8'hFF, '0, 1'b1));
    add_row(OP_APPEND, 64'h4142_0043_4445_4647, 8'h5A, 1'b1,
            make_result(ST_ACK, 6'd2, 64'h4142_0000_0000_0000, 8'h5A, '0, 1'b1));
    add_row(OP_APPEND, 64'h4142_4300_0000_0000, 8'h11, 1'b0, '0);
    add_row(OP_APPEND, 64'h4142_4300_DEAD_BEEF, 8'h22, 1'b0, '0);
    add_row(OP_APPEND, 64'h0000_0000_0000_0001, 8'h33, 1'b0, '0);
    add_row(OP_SPARE_5, '1, 8'hFF, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
    add_row(OP_SPARE_6, '0, 8'h00, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
    add_row(OP_SPARE_7, '1, 8'hA5, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
    add_row(OP_SEARCH, 64'h4142_4300_0000_0000, '0, 1'b0, '0);
    add_row(OP_SORT,   '0, '0, 1'b0, '0);
    add_row(OP_SEARCH, 64'h4142_4300_0000_0000, '0, 1'b0, '0);
    add_row(OP_SEARCH, '1, '0, 1'b0, '0);
    add_row(OP_SEARCH, '0, '0, 1'b0, '0);
    add_row(OP_SEARCH, 64'h4142_4400_0000_0000, '0, 1'b1,
            make_result(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1));
    add_row(OP_MATCH,  64'h4142_4300_FFFF_FFFF, '0, 1'b0, '0);
    add_row(OP_MATCH,  64'h5A00_0000_0000_0000, '0, 1'b1,
            make_result(ST_COUNT, '0, '0, '0, '0, 1'b1));
    add_row(OP_CLEAR,  '1, 8'hFF, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));
    add_row(OP_SORT,   '0, '0, 1'b1, make_result(ST_ACK, '0, '0, '0, '0, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drain_and_set_order(1'b1, 1'b0);

    foreach (directed_rows[r]) begin
      send_op(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
    end

    // The first sequence fills the table past full in descending order under a long stall.
    seq = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (seq == 0) begin
        drain_and_set_order(1'b1, 1'b1);
        long_hold_req <= 1'b1;
      end else begin
        drain_and_set_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if (seq == 0 || $urandom_range(0, 3) != 0) send_random(OP_CLEAR);
      n_app = (seq == 0) ? DEPTH + 2 : $urandom_range(0, 10);
      repeat (n_app) send_random(OP_APPEND);
      if ($urandom_range(0, 3) == 0) send_random(3'($urandom_range(0, 7)));
      send_random(OP_SORT);
      repeat ($urandom_range(1, 6)) send_random($urandom_range(0, 1) ? OP_SEARCH : OP_MATCH);
      if ($urandom_range(0, 4) == 0) begin
        send_random(OP_APPEND);
        send_random(OP_SEARCH);
      end
      seq++;
    end

    drain_and_set_order(1'b0, 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sktbl_pkg.sv
rtl/sktbl_ram.sv
rtl/sorted_key_table_search_unit.sv
dv/tb_sorted_key_table_search_unit.sv
